@@ src/lsc_pkg.sv @@
// lsc_pkg: shared widths, constants, register codes and types for the
// laser scan corridor obstacle check. No dependencies.

package lsc_pkg;

  // Fixed-point setup
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int SINE_DEPTH      = 1024;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Field widths
  localparam int RANGE_W = 16;
  localparam int START_W = 16;
  localparam int STEP_W  = 12;
  localparam int FOOT_W  = 16;
  localparam int DIST_W  = 16;
  localparam int BEAM_W  = 17;
  localparam int SINE_W  = 15;              // magnitude, Q1.14, 0..16384
  localparam int SINE_FRAC = 14;
  localparam int FOOT_SHIFT = SINE_FRAC - 1; // half footprint in Q14

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE,
    REG_ANGLE_START,
    REG_ANGLE_STEP,
    REG_FOOTPRINT,
    REG_OBST_DIST
  } cfg_reg_e;

  // Reset values
  localparam logic [START_W-1:0] ANGLE_START_RST = 16'hF800; // -2048
  localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 12'd7;
  localparam logic [FOOT_W-1:0]  FOOTPRINT_RST   = 16'd600;
  localparam logic [DIST_W-1:0]  OBST_DIST_RST   = 16'd2000;

  // Register stages inside the sine lookup
  localparam int SINE_LAT = 4;

  typedef struct packed {
    logic               enable;
    logic [START_W-1:0] angle_start;
    logic [STEP_W-1:0]  angle_step;
    logic [FOOT_W-1:0]  footprint_mm;
    logic [DIST_W-1:0]  obstacle_distance_mm;
  } cfg_t;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_DEPTH+1];

endpackage

@@ src/lsc_if.sv @@
// lsc_sample_if / lsc_result_if: valid/ready channels for range samples
// and scan results. Depends on lsc_pkg.

interface lsc_sample_if import lsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic               last;

  modport source (output valid, output range_mm, output last, input ready);
  modport sink   (input valid, input range_mm, input last, output ready);
endinterface

interface lsc_result_if ();
  logic valid;
  logic ready;
  logic obstacle;

  modport source (output valid, output obstacle, input ready);
  modport sink   (input valid, input obstacle, output ready);
endinterface

@@ src/lsc_cfg.sv @@
// lsc_cfg: configuration register file, write-only port.
// Depends on lsc_pkg.

module lsc_cfg import lsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable               <= 1'b0;
      cfg.angle_start          <= ANGLE_START_RST;
      cfg.angle_step           <= ANGLE_STEP_RST;
      cfg.footprint_mm         <= FOOTPRINT_RST;
      cfg.obstacle_distance_mm <= OBST_DIST_RST;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_idx))
        REG_ENABLE:      cfg.enable               <= cfg_data[0];
        REG_ANGLE_START: cfg.angle_start          <= cfg_data[START_W-1:0];
        REG_ANGLE_STEP:  cfg.angle_step           <= cfg_data[STEP_W-1:0];
        REG_FOOTPRINT:   cfg.footprint_mm         <= cfg_data[FOOT_W-1:0];
        REG_OBST_DIST:   cfg.obstacle_distance_mm <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/lsc_sine.sv @@
// lsc_sine: pipelined sin(|angle|) lookup. Turn reduction, quadrant fold,
// index scaling and a registered table read. Depends on lsc_pkg.

module lsc_sine import lsc_pkg::*; (
  input  logic                     clk,
  input  logic                     adv,
  input  logic [BEAM_W-1:0]        angle,
  output logic signed [SINE_W:0]   sine
);

  localparam int MAG_W  = BEAM_W;
  localparam int HP_SH  = 30 - ANGLE_FRAC_BITS;
  localparam longint unsigned HP   = (HALF_PI_Q30 + (64'd1 << (HP_SH - 1))) >> HP_SH;
  localparam longint unsigned TURN = 4 * HP;
  localparam int HP_W   = $clog2(HP + 1);
  localparam int TURN_W = $clog2(TURN);
  localparam int RED_W  = (MAG_W > TURN_W) ? MAG_W : TURN_W;
  localparam int IDX_W  = $clog2(SINE_DEPTH + 1);
  localparam int RCP_SH = 32;

  localparam longint unsigned M_TURN = (64'd1 << RCP_SH) / TURN;
  localparam int MT_W = $clog2(M_TURN + 1);
  localparam longint unsigned QT_MAX = (64'd1 << MAG_W) / TURN;
  localparam int QT_W = $clog2(QT_MAX + 2);
  localparam int PT_W = MAG_W + MT_W;

  localparam longint unsigned M_IDX = ((64'd1 << RCP_SH) * SINE_DEPTH) / HP;
  localparam int MI_W = $clog2(M_IDX + 1);
  localparam int PI_W = HP_W + MI_W;
  localparam int IP_W = HP_W + IDX_W + 1;

  localparam logic [MT_W-1:0]  M_TURN_V = MT_W'(M_TURN);
  localparam logic [MI_W-1:0]  M_IDX_V  = MI_W'(M_IDX);
  localparam logic [RED_W-1:0] TURN_R   = RED_W'(TURN);
  localparam logic [RED_W-1:0] HP1_R    = RED_W'(HP);
  localparam logic [RED_W-1:0] HP2_R    = RED_W'(2 * HP);
  localparam logic [RED_W-1:0] HP3_R    = RED_W'(3 * HP);
  localparam logic [HP_W-1:0]  HP_V     = HP_W'(HP);

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned t;
    longint          sum;
    longint          v;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x   = HALF_PI_Q30 * longint'(i) / SINE_DEPTH;
      t   = x;
      sum = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        case (k)
          1: t = t / 6;
          2: t = t / 20;
          3: t = t / 42;
          4: t = t / 72;
          5: t = t / 110;
          6: t = t / 156;
          7: t = t / 210;
          8: t = t / 272;
          default: t = t;
        endcase
        if ((k & 1) == 1) sum = sum - longint'(t);
        else              sum = sum + longint'(t);
      end
      if (sum < 0) sum = 0;
      v = (sum + 32768) >> 16;
      if (v > 16384) v = 16384;
      rom[i] = SINE_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // stage 2: magnitude and turn count estimate
  logic [MAG_W-1:0] mag;
  logic [PT_W-1:0]  turn_prod;
  logic [MAG_W-1:0] mag_q;
  logic [QT_W-1:0]  qt_q;

  assign mag       = angle[BEAM_W-1] ? (~angle + 1'b1) : angle;
  assign turn_prod = PT_W'(mag) * PT_W'(M_TURN_V);

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_q <= mag;
      qt_q  <= QT_W'(turn_prod >> RCP_SH);
    end
  end

  // stage 3: remainder, quadrant fold
  logic [RED_W-1:0] rem0;
  logic [RED_W-1:0] rem;
  logic [RED_W-1:0] fold;
  logic             odd_q;
  logic             neg;
  logic [HP_W-1:0]  v_q3;
  logic             neg_q3;

  always_comb begin
    rem0 = RED_W'(mag_q) - RED_W'(RED_W'(qt_q) * TURN_R);
    rem  = (rem0 >= TURN_R) ? rem0 - TURN_R : rem0;
    if (rem < HP1_R) begin
      fold = rem;          odd_q = 1'b0; neg = 1'b0;
    end else if (rem < HP2_R) begin
      fold = rem - HP1_R;  odd_q = 1'b1; neg = 1'b0;
    end else if (rem < HP3_R) begin
      fold = rem - HP2_R;  odd_q = 1'b0; neg = 1'b1;
    end else begin
      fold = rem - HP3_R;  odd_q = 1'b1; neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_q3   <= odd_q ? (HP_V - HP_W'(fold)) : HP_W'(fold);
      neg_q3 <= neg;
    end
  end

  // stage 4: table index estimate
  logic [PI_W-1:0]  idx_prod;
  logic [HP_W-1:0]  v_q4;
  logic [IDX_W-1:0] est_q4;
  logic             neg_q4;

  assign idx_prod = PI_W'(v_q3) * PI_W'(M_IDX_V);

  always_ff @(posedge clk) begin
    if (adv) begin
      v_q4   <= v_q3;
      est_q4 <= IDX_W'(idx_prod >> RCP_SH);
      neg_q4 <= neg_q3;
    end
  end

  // stage 5: index correction and table read
  logic [IDX_W:0]   est_p1;
  logic [IP_W-1:0]  chk_l;
  logic [IP_W-1:0]  chk_r;
  logic [IDX_W-1:0] idx;
  logic [SINE_W-1:0] mag_q5;
  logic              neg_q5;

  always_comb begin
    est_p1 = {1'b0, est_q4} + 1'b1;
    chk_l  = IP_W'(est_p1) * IP_W'(HP_V);
    chk_r  = IP_W'(v_q4) * IP_W'(SINE_DEPTH);
    idx    = (chk_l <= chk_r) ? est_p1[IDX_W-1:0] : est_q4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_q5 <= SINE_ROM[idx];
      neg_q5 <= neg_q4;
    end
  end

  assign sine = neg_q5 ? -$signed({1'b0, mag_q5}) : $signed({1'b0, mag_q5});

endmodule

@@ src/laser_scan_corridor_obstacle_check.sv @@
// A last-marked sample's result is taken from the final stage into the output register.
// Throughput: one sample per cycle; input stalls only while a result sits at
// the final stage and the output register still holds an untaken result.
// Depth is set by the sine lookup (turn reduction, index scaling, table read).
// Reset (rst, synchronous): config to defaults, beam angle to start, pipeline
// and output emptied, hit flag cleared. Depends on lsc_pkg, lsc_if, lsc_cfg, lsc_sine.

module laser_scan_corridor_obstacle_check import lsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  lsc_sample_if.sink            samples,
  lsc_result_if.source          results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTG = SINE_LAT + 1;
  localparam int LAST = NSTG - 1;
  localparam int LAT_W = RANGE_W + SINE_W + 2;
  localparam logic signed [BEAM_W:0] BEAM_MAX = (BEAM_W+1)'((1 << (BEAM_W - 1)) - 1);

  cfg_t cfg;

  lsc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  logic adv;
  logic acc;
  logic [NSTG-1:0]    vld;
  logic [RANGE_W-1:0] rng_p  [NSTG];
  logic               last_p [NSTG];
  logic               en_p   [NSTG];
  logic               ovalid;
  logic               obstacle;
  logic               hit_seen;

  assign adv = !(vld[LAST] && last_p[LAST] && en_p[LAST] && ovalid && !results.ready);
  assign acc = samples.valid && adv;
  assign samples.ready = adv;

  // beam angle tracker
  logic [BEAM_W-1:0]        beam;
  logic [BEAM_W-1:0]        start_ext;
  logic [BEAM_W-1:0]        start_wr;
  logic signed [BEAM_W:0]   beam_sum;
  logic [BEAM_W-1:0]        beam_next;
  logic [BEAM_W-1:0]        ang_q;

  assign start_ext = {{(BEAM_W-START_W){cfg.angle_start[START_W-1]}}, cfg.angle_start};
  assign start_wr  = {{(BEAM_W-START_W){cfg_data[START_W-1]}}, cfg_data[START_W-1:0]};

  always_comb begin
    beam_sum = $signed({beam[BEAM_W-1], beam})
             + $signed({{(BEAM_W+1-STEP_W){1'b0}}, cfg.angle_step});
    if (!cfg.enable || samples.last) begin
      beam_next = start_ext;
    end else if (beam_sum > BEAM_MAX) begin
      beam_next = BEAM_MAX[BEAM_W-1:0];
    end else begin
      beam_next = beam_sum[BEAM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam <= {{(BEAM_W-START_W){ANGLE_START_RST[START_W-1]}}, ANGLE_START_RST};
    end else if (cfg_we && cfg_idx == REG_ANGLE_START) begin
      beam <= start_wr;
    end else if (acc) begin
      beam <= beam_next;
    end
  end

  // sample pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rng_p[0]  <= samples.range_mm;
      last_p[0] <= samples.last;
      en_p[0]   <= cfg.enable;
      ang_q     <= beam;
      for (int k = 1; k < NSTG; k++) begin
        rng_p[k]  <= rng_p[k-1];
        last_p[k] <= last_p[k-1];
        en_p[k]   <= en_p[k-1];
      end
    end
  end

  logic signed [SINE_W:0] sine;

  lsc_sine u_sine (
    .clk   (clk),
    .adv   (adv),
    .angle (ang_q),
    .sine  (sine)
  );

  // corridor test
  logic signed [LAT_W-1:0] lat;
  logic signed [LAT_W-1:0] lim;
  logic                    hit;

  assign lat = $signed({1'b0, rng_p[LAST]}) * sine;
  assign lim = LAT_W'({cfg.footprint_mm, {FOOT_SHIFT{1'b0}}});
  assign hit = (rng_p[LAST] < cfg.obstacle_distance_mm) && (lat < lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid   <= 1'b0;
      hit_seen <= 1'b0;
    end else begin
      if (adv && vld[LAST] && en_p[LAST] && last_p[LAST]) begin
        ovalid <= 1'b1;
      end else if (results.ready) begin
        ovalid <= 1'b0;
      end
      if (adv && vld[LAST]) begin
        if (!en_p[LAST]) begin
          hit_seen <= 1'b0;
        end else if (last_p[LAST]) begin
          obstacle <= hit_seen | hit;
          hit_seen <= 1'b0;
        end else begin
          hit_seen <= hit_seen | hit;
        end
      end
    end
  end

  assign results.valid    = ovalid;
  assign results.obstacle = obstacle;

endmodule

@@ src/lsc_checker.sv @@
// lsc_checker: port-level assertions for the corridor obstacle check,
// bound to the top level. Depends on lsc_pkg.

module lsc_checker import lsc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  obstacle,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_idx,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic en_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_sh <= 1'b0;
    end else if (cfg_we && cfg_idx == REG_ENABLE) begin
      en_sh <= cfg_data[0];
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(obstacle))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_no_result_disabled: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> en_sh)
    else $error("result produced while disabled");

endmodule

bind laser_scan_corridor_obstacle_check lsc_checker u_lsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .obstacle  (results.obstacle),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx),
  .cfg_data  (cfg_data)
);
